/* src/smt_pkg.sv */
// Shared constants, types and helpers for the systolic int8 matmul tile.
package smt_pkg;

  localparam int ARRAY_DIM = 4;
  localparam int CELLS     = ARRAY_DIM * ARRAY_DIM;
  localparam int CELL_W    = $clog2(CELLS);
  localparam int IDX_W     = $clog2(ARRAY_DIM);
  localparam int DATA_W    = 32;
  localparam int OPND_W    = 8;
  localparam int ADDR_W    = 5;
  localparam int PHASE_W   = 2;

  localparam logic [DATA_W-1:0] ID_WORD     = 32'hCAFEBABE;
  localparam logic [ADDR_W-1:0] REG_CTRL    = 5'd0;
  localparam int                RESULT_BASE = 16;
  localparam int                CTL_STEP_BIT  = 0;
  localparam int                CTL_CLEAR_BIT = 1;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_READ  = 1'b1
  } action_t;

  typedef struct packed {
    logic step;
    logic clear;
  } cell_ctl_t;

  function automatic logic [OPND_W-1:0] pick_byte(input logic [DATA_W-1:0] word,
                                                  input logic [PHASE_W-1:0] phase);
    pick_byte = word[8*phase +: OPND_W];
  endfunction

endpackage

/* src/smt_if.sv */
// Valid/ready channel interfaces for bus accesses and read results.
interface smt_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [smt_pkg::ADDR_W-1:0]   reg_index;
  logic [smt_pkg::DATA_W-1:0]   write_data;

  modport source (output valid, input ready, output action, output reg_index,
                  output write_data);
  modport sink   (input valid, output ready, input action, input reg_index,
                  input write_data);
endinterface

interface smt_out_if;
  logic                         valid;
  logic                         ready;
  logic [smt_pkg::DATA_W-1:0]   read_data;

  modport source (output valid, input ready, output read_data);
  modport sink   (input valid, output ready, input read_data);
endinterface

/* src/smt_cell.sv */
// One multiply-accumulate cell: operand pipe registers and a wrapping accumulator.
module smt_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  smt_pkg::cell_ctl_t            ctl,
  input  logic [smt_pkg::OPND_W-1:0]    h_in,
  input  logic [smt_pkg::OPND_W-1:0]    v_in,
  output logic [smt_pkg::OPND_W-1:0]    h_out,
  output logic [smt_pkg::OPND_W-1:0]    v_out,
  output logic [smt_pkg::DATA_W-1:0]    acc
);

  logic [smt_pkg::OPND_W-1:0] h_r, v_r;
  logic [smt_pkg::DATA_W-1:0] acc_r, acc_nxt;
  logic signed [2*smt_pkg::OPND_W-1:0] prod;

  always_comb begin
    prod    = $signed(h_in) * $signed(v_in);
    acc_nxt = acc_r + {{(smt_pkg::DATA_W-2*smt_pkg::OPND_W){prod[2*smt_pkg::OPND_W-1]}},
                       prod};
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      h_r   <= '0;
      v_r   <= '0;
      acc_r <= '0;
    end else if (ctl.step) begin
      h_r   <= h_in;
      v_r   <= v_in;
      acc_r <= acc_nxt;
    end
  end

  assign h_out = h_r;
  assign v_out = v_r;
  assign acc   = acc_r;

endmodule

/* src/systolic_int8_matmul_tile_unit.sv */
// Top level: register map, operand words, cell grid and buffered read results.
//
//  channel   dir  handshake        payload
//  in_bus    in   valid / ready    action, reg_index, write_data
//  out_bus   out  valid / ready    read_data (one beat per input beat)
//
// One bus beat per cycle while in_bus.ready is high; a STEP updates every cell in
// the cycle it is accepted. Each result is registered before it reaches out_bus.
// A two-entry output buffer (output register plus skid) holds results while
// out_bus stalls; in_bus.ready drops only when both entries are full.
// Reset is synchronous, active low, and clears all words, pipes and accumulators.
module systolic_int8_matmul_tile_unit (
  input  logic      clk,
  input  logic      rst_n,
  smt_in_if.sink    in_bus,
  smt_out_if.source out_bus
);

  localparam int DIM = smt_pkg::ARRAY_DIM;

  logic [smt_pkg::DATA_W-1:0] row_words_r [DIM];
  logic [smt_pkg::DATA_W-1:0] col_words_r [DIM];
  logic [smt_pkg::PHASE_W-1:0] phase_r;

  logic [smt_pkg::OPND_W-1:0] h_q [smt_pkg::CELLS];
  logic [smt_pkg::OPND_W-1:0] v_q [smt_pkg::CELLS];
  logic [smt_pkg::DATA_W-1:0] acc_q [smt_pkg::CELLS];

  logic push, pop, is_wr, is_rd, wr_ctrl, wr_clear, wr_step, wr_row, wr_col, rd_res;
  logic [31:0] row_off, col_off, res_off;
  logic [smt_pkg::DATA_W-1:0] result;
  smt_pkg::cell_ctl_t ctl;

  logic out_valid_r, skid_valid_r;
  logic [smt_pkg::DATA_W-1:0] out_data_r, skid_data_r;

  // decode
  always_comb begin
    push     = in_bus.valid && in_bus.ready;
    is_rd    = (in_bus.action == smt_pkg::ACT_READ);
    is_wr    = (in_bus.action == smt_pkg::ACT_WRITE);
    row_off  = 32'(in_bus.reg_index) - 32'd1;
    col_off  = 32'(in_bus.reg_index) - 32'd1 - 32'(DIM);
    res_off  = 32'(in_bus.reg_index) - 32'(smt_pkg::RESULT_BASE);
    wr_ctrl  = push && is_wr && (in_bus.reg_index == smt_pkg::REG_CTRL);
    wr_clear = wr_ctrl && in_bus.write_data[smt_pkg::CTL_CLEAR_BIT];
    wr_step  = wr_ctrl && !in_bus.write_data[smt_pkg::CTL_CLEAR_BIT]
               && in_bus.write_data[smt_pkg::CTL_STEP_BIT];
    wr_row   = push && is_wr && (in_bus.reg_index != smt_pkg::REG_CTRL)
               && (row_off < 32'(DIM));
    wr_col   = push && is_wr && (in_bus.reg_index != smt_pkg::REG_CTRL)
               && (row_off >= 32'(DIM)) && (col_off < 32'(DIM));
    rd_res   = (32'(in_bus.reg_index) >= 32'(smt_pkg::RESULT_BASE))
               && (res_off < 32'(smt_pkg::CELLS));
    ctl.step  = wr_step;
    ctl.clear = wr_clear;
  end

  always_comb begin
    result = '0;
    if (is_rd) begin
      if (in_bus.reg_index == smt_pkg::REG_CTRL) begin
        result = smt_pkg::ID_WORD;
      end else if (rd_res) begin
        result = acc_q[res_off[smt_pkg::CELL_W-1:0]];
      end
    end
  end

  // operand words and phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIM; k++) begin
        row_words_r[k] <= '0;
        col_words_r[k] <= '0;
      end
      phase_r <= '0;
    end else begin
      if (wr_row) begin
        row_words_r[row_off[smt_pkg::IDX_W-1:0]] <= in_bus.write_data;
      end
      if (wr_col) begin
        col_words_r[col_off[smt_pkg::IDX_W-1:0]] <= in_bus.write_data;
      end
      if (wr_clear) begin
        phase_r <= '0;
      end else if (wr_step) begin
        phase_r <= phase_r + 2'd1;
      end
    end
  end

  // cell grid
  for (genvar i = 0; i < DIM; i++) begin : g_row
    for (genvar j = 0; j < DIM; j++) begin : g_col
      logic [smt_pkg::OPND_W-1:0] h_src, v_src;
      if (j == 0) begin : g_hl
        assign h_src = smt_pkg::pick_byte(row_words_r[i], phase_r);
      end else begin : g_hn
        assign h_src = h_q[i*DIM + j - 1];
      end
      if (i == 0) begin : g_vt
        assign v_src = smt_pkg::pick_byte(col_words_r[j], phase_r);
      end else begin : g_vn
        assign v_src = v_q[(i-1)*DIM + j];
      end
      smt_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .h_in  (h_src),
        .v_in  (v_src),
        .h_out (h_q[i*DIM + j]),
        .v_out (v_q[i*DIM + j]),
        .acc   (acc_q[i*DIM + j])
      );
    end
  end

  // output register and skid
  assign pop           = out_valid_r && out_bus.ready;
  assign in_bus.ready  = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || pop) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r  <= push;
        end
      end else if (push) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (push) begin
        out_data_r <= result;
      end
    end else if (push) begin
      skid_data_r <= result;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.read_data = out_data_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_clear_phase: assert property (@(posedge clk) disable iff (!rst_n)
    wr_clear |=> (phase_r == '0))
    else $error("phase not zero after clear");

  a_step_phase: assert property (@(posedge clk) disable iff (!rst_n)
    wr_step |=> (phase_r == $past(phase_r) + 2'd1))
    else $error("phase did not advance on step");

  a_beat_fills: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid_r)
    else $error("accepted beat left no result");

endmodule

/* tb/tb.sv */
// Self-checking testbench for the systolic int8 matmul tile bus map and cell grid.
`timescale 1ns / 100ps

module tb;
  import smt_pkg::*;

  localparam logic [ADDR_W-1:0] REG_ROW0 = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] REG_COL0 = ADDR_W'(1 + ARRAY_DIM);
  localparam logic [ADDR_W-1:0] REG_RES0 = ADDR_W'(RESULT_BASE);
  localparam logic [ADDR_W-1:0] REG_LAST = ADDR_W'(31);
  localparam logic [ADDR_W-1:0] REG_HOLE = ADDR_W'(12);
  localparam logic [DATA_W-1:0] CTL_STEP  = DATA_W'(1) << CTL_STEP_BIT;
  localparam logic [DATA_W-1:0] CTL_CLEAR = DATA_W'(1) << CTL_CLEAR_BIT;
  localparam int RANDOM_BEATS = 1600;
  localparam int NUM_DIRECTED = 26;

  typedef struct packed {
    action_t             act;
    logic [ADDR_W-1:0]   idx;
    logic [DATA_W-1:0]   data;
    logic                typed;
    logic [DATA_W-1:0]   want;
  } bus_row_t;

  localparam bus_row_t DIRECTED [NUM_DIRECTED] = '{
    '{ACT_READ,  REG_CTRL,     32'h0000_0000, 1'b1, ID_WORD},
    '{ACT_READ,  REG_RES0,     32'hFFFF_FFFF, 1'b1, 32'h0},
    '{ACT_READ,  REG_LAST,     32'h0000_0000, 1'b1, 32'h0},
    '{ACT_WRITE, REG_ROW0,     32'h807F_807F, 1'b1, 32'h0},
    '{ACT_WRITE, REG_ROW0 + ADDR_W'(1), 32'h7F7F_7F7F, 1'b1, 32'h0},
    '{ACT_WRITE, REG_ROW0 + ADDR_W'(2), 32'h8080_8080, 1'b1, 32'h0},
    '{ACT_WRITE, REG_ROW0 + ADDR_W'(3), 32'hFFFF_FFFF, 1'b1, 32'h0},
    '{ACT_WRITE, REG_COL0,     32'h8080_8080, 1'b1, 32'h0},
    '{ACT_WRITE, REG_COL0 + ADDR_W'(1), 32'h807F_807F, 1'b1, 32'h0},
    '{ACT_WRITE, REG_COL0 + ADDR_W'(2), 32'h01FF_01FF, 1'b1, 32'h0},
    '{ACT_WRITE, REG_COL0 + ADDR_W'(3), 32'h0000_0000, 1'b1, 32'h0},
    '{ACT_READ,  REG_ROW0,     32'h0000_0000, 1'b1, 32'h0},
    '{ACT_READ,  REG_COL0 + ADDR_W'(3), 32'h0000_0000, 1'b1, 32'h0},
    '{ACT_READ,  REG_COL0 + ADDR_W'(4), 32'h0000_0000, 1'b1, 32'h0},
    '{ACT_WRITE, REG_HOLE,     32'hFFFF_FFFF, 1'b1, 32'h0},
    '{ACT_WRITE, REG_RES0,     32'hFFFF_FFFF, 1'b1, 32'h0},
    '{ACT_WRITE, REG_CTRL,     32'hFFFF_FFFC, 1'b1, 32'h0},
    '{ACT_WRITE, REG_CTRL,     CTL_STEP,      1'b0, 32'h0},
    '{ACT_READ,  REG_RES0,     32'h0000_0000, 1'b0, 32'h0},
    '{ACT_WRITE, REG_CTRL,     32'hFFFF_FFFD, 1'b0, 32'h0},
    '{ACT_WRITE, REG_CTRL,     CTL_STEP,      1'b0, 32'h0},
    '{ACT_READ,  REG_RES0 + ADDR_W'(5), 32'h0000_0000, 1'b0, 32'h0},
    '{ACT_READ,  REG_LAST,     32'h0000_0000, 1'b0, 32'h0},
    '{ACT_WRITE, REG_CTRL,     CTL_STEP | CTL_CLEAR, 1'b1, 32'h0},
    '{ACT_READ,  REG_RES0,     32'h0000_0000, 1'b1, 32'h0},
    '{ACT_READ,  REG_LAST,     32'h0000_0000, 1'b1, 32'h0}
  };

  logic clk;
  logic rst_n;

  smt_in_if  in_ch();
  smt_out_if out_ch();

  systolic_int8_matmul_tile_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  logic [DATA_W-1:0]        row_reg [ARRAY_DIM];
  logic [DATA_W-1:0]        col_reg [ARRAY_DIM];
  logic signed [OPND_W-1:0] east_pipe [CELLS];
  logic signed [OPND_W-1:0] south_pipe [CELLS];
  logic [DATA_W-1:0]        acc [CELLS];
  logic [PHASE_W-1:0]       phase;

  logic [DATA_W-1:0] expected_reads [$];
  int mismatches;
  int useful_beats;
  int checked_beats;
  int send_idle_pct;
  int recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("systolic_int8_matmul_tile_unit test failed");
    $finish;
  end

  function automatic void clear_grid();
    for (int c = 0; c < CELLS; c++) begin
      east_pipe[c]  = '0;
      south_pipe[c] = '0;
      acc[c]        = '0;
    end
    phase = '0;
  endfunction

  function automatic void step_grid();
    logic signed [DATA_W-1:0] prod;
    for (int i = 0; i < ARRAY_DIM; i++) begin
      for (int j = ARRAY_DIM - 1; j > 0; j--)
        east_pipe[i*ARRAY_DIM + j] = east_pipe[i*ARRAY_DIM + j - 1];
      east_pipe[i*ARRAY_DIM] = row_reg[i][8*phase +: OPND_W];
    end
    for (int j = 0; j < ARRAY_DIM; j++) begin
      for (int i = ARRAY_DIM - 1; i > 0; i--)
        south_pipe[i*ARRAY_DIM + j] = south_pipe[(i-1)*ARRAY_DIM + j];
      south_pipe[j] = col_reg[j][8*phase +: OPND_W];
    end
    for (int c = 0; c < CELLS; c++) begin
      prod   = east_pipe[c] * south_pipe[c];
      acc[c] = acc[c] + prod;
    end
    phase = phase + 1'b1;
  endfunction

  function automatic logic [DATA_W-1:0] predict_access(action_t act, logic [ADDR_W-1:0] idx,
                                                       logic [DATA_W-1:0] data);
    int off;
    off = int'(idx);
    if (act == ACT_READ) begin
      if (idx == REG_CTRL) return ID_WORD;
      if (off >= RESULT_BASE && off - RESULT_BASE < CELLS) return acc[off - RESULT_BASE];
      return '0;
    end
    if (idx == REG_CTRL) begin
      if (data[CTL_CLEAR_BIT]) clear_grid();
      else if (data[CTL_STEP_BIT]) step_grid();
    end else if (off <= ARRAY_DIM) begin
      row_reg[off - 1] = data;
    end else if (off <= 2*ARRAY_DIM) begin
      col_reg[off - 1 - ARRAY_DIM] = data;
    end
    return '0;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("MISMATCH beat %0d %s: read_data got %h want %h", checked_beats, what, got, want);
    mismatches++;
  endtask

  // Enter and leave at a falling edge; valid stays high until the next beat decides.
  task automatic send_beat(action_t act, logic [ADDR_W-1:0] idx, logic [DATA_W-1:0] data,
                           logic typed = 1'b0, logic [DATA_W-1:0] want = '0);
    logic [DATA_W-1:0] predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.action     = act;
    in_ch.reg_index  = idx;
    in_ch.write_data = data;
    do @(posedge clk); while (!in_ch.ready);
    predicted = predict_access(act, idx, data);
    expected_reads.push_back(typed ? want : predicted);
    if (act == ACT_READ || (int'(idx) <= 2*ARRAY_DIM &&
        (idx != REG_CTRL || data[CTL_STEP_BIT] || data[CTL_CLEAR_BIT])))
      useful_beats++;
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_ch.valid = 1'b0;
    while (expected_reads.size() != 0) @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] rand_operand();
    logic [DATA_W-1:0] w;
    logic [OPND_W-1:0] b;
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(5))
        0: b = 8'h80;
        1: b = 8'h7F;
        2: b = 8'hFF;
        3: b = 8'h00;
        default: b = OPND_W'($urandom);
      endcase
      w[8*k +: OPND_W] = b;
    end
    return w;
  endfunction

  task automatic run_block();
    int n;
    if ($urandom_range(9) < 7) begin
      if ($urandom_range(2) == 0) send_beat(ACT_WRITE, REG_CTRL, $urandom | CTL_CLEAR);
      for (int k = 0; k < 2*ARRAY_DIM; k++)
        if ($urandom_range(7) != 0) send_beat(ACT_WRITE, REG_ROW0 + ADDR_W'(k), rand_operand());
      n = $urandom_range(2*ARRAY_DIM, 1);
      for (int k = 0; k < n; k++) begin
        send_beat(ACT_WRITE, REG_CTRL, ($urandom & ~CTL_CLEAR) | CTL_STEP);
        if ($urandom_range(3) == 0) send_beat(ACT_READ, ADDR_W'($urandom), $urandom);
      end
      for (int c = 0; c < CELLS; c++)
        if ($urandom_range(3) != 0) send_beat(ACT_READ, REG_RES0 + ADDR_W'(c), $urandom);
    end else begin
      repeat ($urandom_range(6, 1))
        send_beat(action_t'($urandom_range(1)), ADDR_W'($urandom), $urandom);
    end
  endtask

  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_reads.size() == 0) report_mismatch("with nothing pending", out_ch.read_data, '0);
      else if (out_ch.read_data !== expected_reads[0])
        report_mismatch("wrong value", out_ch.read_data, expected_reads[0]);
      if (expected_reads.size() != 0) void'(expected_reads.pop_front());
      checked_beats++;
    end
  end

  initial begin
    int base;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.action     = ACT_WRITE;
    in_ch.reg_index  = '0;
    in_ch.write_data = '0;
    out_ch.ready     = 1'b0;
    mismatches       = 0;
    useful_beats     = 0;
    checked_beats    = 0;
    send_idle_pct    = 26;
    recv_idle_pct    = 50;
    for (int k = 0; k < ARRAY_DIM; k++) begin
      row_reg[k] = '0;
      col_reg[k] = '0;
    end
    clear_grid();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int r = 0; r < NUM_DIRECTED; r++)
      send_beat(DIRECTED[r].act, DIRECTED[r].idx, DIRECTED[r].data,
                DIRECTED[r].typed, DIRECTED[r].want);

    base = useful_beats;
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 26 : (p == 1) ? 50 : 0;
      recv_idle_pct = (p == 0) ? 50 : (p == 1) ? 26 : 0;
      while (useful_beats - base < RANDOM_BEATS * (p + 1) / 3) run_block();
      hold_until_drained();
    end

    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("systolic_int8_matmul_tile_unit test passed");
    end else begin
      $display("systolic_int8_matmul_tile_unit test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/smt_pkg.sv
src/smt_if.sv
src/smt_cell.sv
src/systolic_int8_matmul_tile_unit.sv
tb/tb.sv
